>>> rtl/jaxc_pkg.sv
package jaxc_pkg;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CORR = 5'b00010,
    S_MAG  = 5'b00100,
    S_DIV  = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  // Configuration register indexes
  localparam logic [2:0] REG_OFF_S1_X = 3'd0;
  localparam logic [2:0] REG_OFF_S1_Y = 3'd1;
  localparam logic [2:0] REG_OFF_S2_X = 3'd2;
  localparam logic [2:0] REG_OFF_S2_Y = 3'd3;
  localparam logic [2:0] REG_DEAD_BAND = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int OFF_W      = 9;
  localparam int DB_W       = 8;
  localparam int CTL_W      = 7;
  localparam int NUM_AXES   = 4;
  localparam int AX_W       = 2;

  // Control span: full deflection maps to this many steps
  localparam int CTL_SPAN = 50;
  // Quotient bits; the quotient never exceeds the control span
  localparam int Q_BITS   = 6;

  // Reset values of the registers
  localparam logic signed [OFF_W-1:0] OFF_S1_X_RST = 9'sd11;
  localparam logic signed [OFF_W-1:0] OFF_S1_Y_RST = -9'sd5;
  localparam logic signed [OFF_W-1:0] OFF_S2_X_RST = -9'sd28;
  localparam logic signed [OFF_W-1:0] OFF_S2_Y_RST = 9'sd11;
  localparam logic [DB_W-1:0]         DEAD_BAND_RST = 8'd50;

  // Button edge codes
  localparam logic [1:0] EDGE_NONE    = 2'd0;
  localparam logic [1:0] EDGE_PRESS   = 2'd1;
  localparam logic [1:0] EDGE_RELEASE = 2'd2;

endpackage

>>> rtl/jaxc_div.sv
module jaxc_div
  import jaxc_pkg::*;
#(
  parameter int NUM_W = 17,
  parameter int DEN_W = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              done,
  output logic [Q_BITS-1:0] quo
);

  localparam int STEP_W = $clog2(Q_BITS);

  logic              busy_r;
  logic              done_r;
  logic [NUM_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [Q_BITS-1:0] quo_r;
  logic [STEP_W-1:0] step_r;

  logic [NUM_W-1:0]  shifted;
  logic              ge;

  // Restoring division, one quotient bit per cycle, most significant first
  assign shifted = NUM_W'(den_r) << step_r;
  assign ge      = (rem_r >= shifted);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      quo_r  <= '0;
      step_r <= STEP_W'(Q_BITS - 1);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - shifted;
      end
      quo_r  <= {quo_r[Q_BITS-2:0], ge};
      step_r <= step_r - STEP_W'(1);
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> rtl/joystick_axis_and_button_conditioning_core.sv
// Joystick axis and button conditioning.
// Input channel (in_valid / in_stall): one transaction carries four raw
// stick samples and the two active-low button pins. in_stall is high while
// an item is being worked on, so one item is in flight at a time.
// Output channel (out_valid / out_stall): one result transaction per input,
// holding the corrected positions, the deadband-mapped control values and
// the button held / edge flags.
// Per axis the offset add and clamp (S_CORR) and then the magnitude check
// (S_MAG) are done; an axis outside the deadband then runs the shared
// restoring divider (S_DIV). The next item is taken the cycle after the
// result is loaded, so no new item is taken before the last one is through.
// The result sits in an output register: while the receiver stalls a new
// item is still accepted and processed, and only the load of its result
// waits until the held one has gone.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
// ready; writes belong in idle periods. Unknown indexes are ignored.
// Reset restores the default offsets and deadband and marks both buttons
// released; no clearing pass is needed.
module joystick_axis_and_button_conditioning_core
  import jaxc_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [SAMPLE_BITS-1:0]       in_s1_x_raw,
  input  logic [SAMPLE_BITS-1:0]       in_s1_y_raw,
  input  logic [SAMPLE_BITS-1:0]       in_s2_x_raw,
  input  logic [SAMPLE_BITS-1:0]       in_s2_y_raw,
  input  logic                         in_s1_pin,
  input  logic                         in_s2_pin,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [SAMPLE_BITS-1:0]       out_s1_x_pos,
  output logic [SAMPLE_BITS-1:0]       out_s1_y_pos,
  output logic [SAMPLE_BITS-1:0]       out_s2_x_pos,
  output logic [SAMPLE_BITS-1:0]       out_s2_y_pos,
  output logic signed [CTL_W-1:0]      out_s1_x_ctl,
  output logic signed [CTL_W-1:0]      out_s1_y_ctl,
  output logic signed [CTL_W-1:0]      out_s2_x_ctl,
  output logic signed [CTL_W-1:0]      out_s2_y_ctl,
  output logic                         out_s1_held,
  output logic [1:0]                   out_s1_edge,
  output logic                         out_s2_held,
  output logic [1:0]                   out_s2_edge
);

  localparam int SB    = SAMPLE_BITS;
  localparam int SW    = SB + 2;
  localparam int NUM_W = SB + 5;
  localparam logic [SB-1:0] CENTER = {1'b1, {(SB-1){1'b0}}};
  localparam logic [SB-1:0] FULL   = {SB{1'b1}};

  // Configuration registers
  logic signed [OFF_W-1:0] off_s1_x_r, off_s1_y_r, off_s2_x_r, off_s2_y_r;
  logic [DB_W-1:0]         dead_band_r;

  // Sequencer and working storage
  state_t               state_r, state_nxt;
  logic [AX_W-1:0]      ax_r;
  logic [SB-1:0]        raw_r [NUM_AXES];
  logic [SB-1:0]        pos_r [NUM_AXES];
  logic signed [CTL_W-1:0] ctl_r [NUM_AXES];
  logic                 neg_r;
  logic [1:0]           prev_pin_r;
  logic [1:0]           held_r;
  logic [1:0]           edge_r [2];
  logic                 out_valid_r;

  logic                 in_acc;
  logic                 out_load;
  logic                 last_ax;

  logic signed [OFF_W-1:0] off_sel;
  logic signed [SW-1:0]    sum;
  logic [SB-1:0]           clamped;
  logic [SB-1:0]           pos_sel;
  logic [SB-1:0]           ctr_dev;
  logic [SB-1:0]           db_ext;
  logic [SB-1:0]           mag;
  logic                    outside;
  logic [SB-1:0]           range_w;
  logic [NUM_W-1:0]        numer;

  logic                    div_start;
  logic                    div_done;
  logic [Q_BITS-1:0]       div_quo;
  logic signed [CTL_W-1:0] quo_s;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = (state_r == S_HOLD) && (!out_valid_r || !out_stall);
  assign last_ax   = (ax_r == AX_W'(NUM_AXES - 1));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_s1_x_r  <= OFF_S1_X_RST;
      off_s1_y_r  <= OFF_S1_Y_RST;
      off_s2_x_r  <= OFF_S2_X_RST;
      off_s2_y_r  <= OFF_S2_Y_RST;
      dead_band_r <= DEAD_BAND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OFF_S1_X:  off_s1_x_r  <= $signed(cfg_data);
        REG_OFF_S1_Y:  off_s1_y_r  <= $signed(cfg_data);
        REG_OFF_S2_X:  off_s2_x_r  <= $signed(cfg_data);
        REG_OFF_S2_Y:  off_s2_y_r  <= $signed(cfg_data);
        REG_DEAD_BAND: dead_band_r <= cfg_data[DB_W-1:0];
        default: ;
      endcase
    end
  end

  // Offset for the axis in hand
  always_comb begin
    case (ax_r)
      2'd0:    off_sel = off_s1_x_r;
      2'd1:    off_sel = off_s1_y_r;
      2'd2:    off_sel = off_s2_x_r;
      default: off_sel = off_s2_y_r;
    endcase
  end

  // Offset add and clamp to 0..FULL
  always_comb begin
    sum = $signed({2'b00, raw_r[ax_r]}) + SW'(off_sel);
    if (sum[SW-1]) begin
      clamped = '0;
    end else if (sum[SW-2:SB] != '0) begin
      clamped = FULL;
    end else begin
      clamped = sum[SB-1:0];
    end
  end

  // Distance from centre beyond the deadband, scaled by the span
  always_comb begin
    pos_sel = pos_r[ax_r];
    ctr_dev = pos_sel[SB-1] ? (pos_sel - CENTER) : (CENTER - pos_sel);
    db_ext  = SB'(dead_band_r);
    outside = (ctr_dev > db_ext);
    mag     = ctr_dev - db_ext;
    range_w = CENTER - db_ext;
    numer   = NUM_W'(mag) * NUM_W'(CTL_SPAN);
  end

  assign div_start = (state_r == S_MAG) && outside;
  assign quo_s     = $signed({1'b0, div_quo});

  jaxc_div #(
    .NUM_W (NUM_W),
    .DEN_W (SB)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (numer),
    .den   (range_w),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_CORR;
      S_CORR: state_nxt = S_MAG;
      S_MAG: begin
        if (outside) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = last_ax ? S_HOLD : S_CORR;
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = last_ax ? S_HOLD : S_CORR;
      end
      S_HOLD: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= '0;
      prev_pin_r  <= 2'b11;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        ax_r       <= '0;
        prev_pin_r <= {in_s2_pin, in_s1_pin};
      end else if ((state_r == S_MAG && !outside) || (state_r == S_DIV && div_done)) begin
        ax_r <= ax_r + AX_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      raw_r[0]  <= in_s1_x_raw;
      raw_r[1]  <= in_s1_y_raw;
      raw_r[2]  <= in_s2_x_raw;
      raw_r[3]  <= in_s2_y_raw;
      held_r    <= {~in_s2_pin, ~in_s1_pin};
      edge_r[0] <= (prev_pin_r[0] && !in_s1_pin) ? EDGE_PRESS :
                   (!prev_pin_r[0] && in_s1_pin) ? EDGE_RELEASE : EDGE_NONE;
      edge_r[1] <= (prev_pin_r[1] && !in_s2_pin) ? EDGE_PRESS :
                   (!prev_pin_r[1] && in_s2_pin) ? EDGE_RELEASE : EDGE_NONE;
    end
    if (state_r == S_CORR) begin
      pos_r[ax_r] <= clamped;
    end
    if (state_r == S_MAG) begin
      neg_r <= !pos_sel[SB-1];
      if (!outside) begin
        ctl_r[ax_r] <= '0;
      end
    end
    if (state_r == S_DIV && div_done) begin
      ctl_r[ax_r] <= neg_r ? -quo_s : quo_s;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_s1_x_pos <= pos_r[0];
      out_s1_y_pos <= pos_r[1];
      out_s2_x_pos <= pos_r[2];
      out_s2_y_pos <= pos_r[3];
      out_s1_x_ctl <= ctl_r[0];
      out_s1_y_ctl <= ctl_r[1];
      out_s2_x_ctl <= ctl_r[2];
      out_s2_y_ctl <= ctl_r[3];
      out_s1_held  <= held_r[0];
      out_s1_edge  <= edge_r[0];
      out_s2_held  <= held_r[1];
      out_s2_edge  <= edge_r[1];
    end
  end

  assign out_valid = out_valid_r;

  // A new result only appears after the sequencer has finished an item
  a_valid_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_HOLD))
    else $error("result raised outside the hold step");

  // A held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !out_load)
    else $error("held result overwritten");

  // Divider answers only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide step");

  // Control values stay within the span
  a_ctl_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && div_done |-> div_quo <= Q_BITS'(CTL_SPAN))
    else $error("quotient beyond control span");

  // An s1 press edge always reports the button held
  a_press_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_s1_edge == EDGE_PRESS |-> out_s1_held)
    else $error("press edge without held button");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import jaxc_pkg::*;

  localparam int SB             = 12;
  localparam int FULL           = (1 << SB) - 1;
  localparam int CENTER         = 1 << (SB - 1);
  localparam int SEGMENTS       = 10;
  localparam int SEG_ITEMS      = 143;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;

  // One tick of stick samples; index 0..3 = s1_x, s1_y, s2_x, s2_y
  typedef struct packed {
    logic [3:0][SB-1:0] raw;
    logic [1:0]         pin;
  } tick_input_t;

  typedef struct packed {
    logic [3:0][SB-1:0]    pos;
    logic [3:0][CTL_W-1:0] ctl;
    logic [1:0]            held;
    logic [1:0][1:0]       edge_code;
  } tick_result_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  tick_input_t           in_tick   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;

  logic [3:0][SB-1:0]    seen_pos;
  logic [3:0][CTL_W-1:0] seen_ctl;
  logic [1:0]            seen_held;
  logic [1:0][1:0]       seen_edge;

  // Shadow of the block's registers and button history
  logic signed [OFF_W-1:0] off_reg [4] =
    '{OFF_S1_X_RST, OFF_S1_Y_RST, OFF_S2_X_RST, OFF_S2_Y_RST};
  logic [DB_W-1:0] db_reg    = DEAD_BAND_RST;
  logic [1:0]      last_pins = 2'b11;

  tick_input_t  pending_q  [$];
  tick_result_t expected_q [$];

  int   mismatches    = 0;
  int   cfg_writes    = 0;
  logic in_done       = 1'b0;
  int   in_gap_pct    = 0;
  int   out_stall_pct = 0;
  int   gap_left      = 0;
  int   stall_left    = 0;
  int   quiet_cycles  = 0;
  int   pin_phase     = 0;
  int   idle_levels [4] = '{0, 5, 25, 50};

  string axis_name   [4] = '{"s1_x", "s1_y", "s2_x", "s2_y"};
  string button_name [2] = '{"s1", "s2"};

  joystick_axis_and_button_conditioning_core #(.SAMPLE_BITS(SB)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_s1_x_raw  (in_tick.raw[0]),
    .in_s1_y_raw  (in_tick.raw[1]),
    .in_s2_x_raw  (in_tick.raw[2]),
    .in_s2_y_raw  (in_tick.raw[3]),
    .in_s1_pin    (in_tick.pin[0]),
    .in_s2_pin    (in_tick.pin[1]),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_s1_x_pos (seen_pos[0]),
    .out_s1_y_pos (seen_pos[1]),
    .out_s2_x_pos (seen_pos[2]),
    .out_s2_y_pos (seen_pos[3]),
    .out_s1_x_ctl (seen_ctl[0]),
    .out_s1_y_ctl (seen_ctl[1]),
    .out_s2_x_ctl (seen_ctl[2]),
    .out_s2_y_ctl (seen_ctl[3]),
    .out_s1_held  (seen_held[0]),
    .out_s1_edge  (seen_edge[0]),
    .out_s2_held  (seen_held[1]),
    .out_s2_edge  (seen_edge[1])
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Offset add, then saturate to the sample range
  function automatic logic [SB-1:0] clamp_axis(logic [SB-1:0] raw,
                                               logic signed [OFF_W-1:0] off);
    int r;
    int o;
    int s;
    r = raw;
    o = off;
    s = r + o;
    if (s < 0) return '0;
    if (s > FULL) return SB'(FULL);
    return SB'(s);
  endfunction

  // Zero zone around centre, linear scale outside it, truncating division
  function automatic logic [CTL_W-1:0] deadband_map(logic [SB-1:0] pos,
                                                    logic [DB_W-1:0] db);
    int d;
    int w;
    int span;
    int q;
    d    = int'(pos) - CENTER;
    w    = db;
    span = CENTER - w;
    if (d > w) q = (d - w) * CTL_SPAN / span;
    else if (d < -w) q = -(((-d) - w) * CTL_SPAN / span);
    else q = 0;
    return CTL_W'(q);
  endfunction

  function automatic tick_result_t condition_tick(tick_input_t t, logic [1:0] prev);
    tick_result_t r;
    for (int k = 0; k < 4; k++) begin
      r.pos[k] = clamp_axis(t.raw[k], off_reg[k]);
      r.ctl[k] = deadband_map(r.pos[k], db_reg);
    end
    for (int b = 0; b < 2; b++) begin
      r.held[b] = ~t.pin[b];
      if (prev[b] && !t.pin[b]) r.edge_code[b] = EDGE_PRESS;
      else if (!prev[b] && t.pin[b]) r.edge_code[b] = EDGE_RELEASE;
      else r.edge_code[b] = EDGE_NONE;
    end
    return r;
  endfunction

  // Raw sample that lands the corrected value on a target, where reachable
  function automatic logic [SB-1:0] aim_axis(int target, int k);
    int raw;
    raw = target - int'(off_reg[k]);
    if (raw < 0) raw = 0;
    if (raw > FULL) raw = FULL;
    return SB'(raw);
  endfunction

  // Mix of uniform samples, deadband edges and clamp edges
  function automatic logic [SB-1:0] rand_axis(int k);
    int w;
    w = db_reg;
    case ($urandom_range(0, 7))
      0, 1, 2: return SB'($urandom_range(0, FULL));
      3: return aim_axis(CENTER - w - 4 + int'($urandom_range(0, 2 * w + 8)), k);
      4: return aim_axis(($urandom_range(0, 1) ? CENTER + w : CENTER - w)
                         + int'($urandom_range(0, 2)) - 1, k);
      5: return SB'($urandom_range(0, 300));
      6: return SB'($urandom_range(FULL - 300, FULL));
      default: return aim_axis(($urandom_range(0, 1) ? -2 : FULL - 2)
                               + int'($urandom_range(0, 4)), k);
    endcase
  endfunction

  // Pins walk through none / press / held / release on both buttons
  task automatic queue_tick(logic [3:0][SB-1:0] raw);
    tick_input_t t;
    t.raw    = raw;
    t.pin[0] = (pin_phase % 4 == 1 || pin_phase % 4 == 2) ? 1'b0 : 1'b1;
    t.pin[1] = (pin_phase % 4 == 0 || pin_phase % 4 == 1) ? 1'b0 : 1'b1;
    pin_phase++;
    pending_q.push_back(t);
  endtask

  task automatic queue_directed(bit full_set);
    int w;
    int targets [$];
    logic [3:0][SB-1:0] raw;
    w = db_reg;
    queue_tick('0);
    queue_tick('1);
    if (full_set)
      targets = '{-1, 0, 1, CENTER - w - 1, CENTER - w, CENTER, CENTER + w,
                  CENTER + w + 1, FULL, FULL + 1};
    else
      targets = '{0, CENTER - w - 1, CENTER + w + 1, FULL + 1};
    foreach (targets[i]) begin
      for (int k = 0; k < 4; k++) raw[k] = aim_axis(targets[i], k);
      queue_tick(raw);
    end
  endtask

  // Call at a falling edge; returns at the falling edge after the write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int seen;
    seen = cfg_writes;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (cfg_writes == seen);
  endtask

  task automatic write_settings(logic [3:0][OFF_W-1:0] offs,
                                logic [CFG_DATA_W-1:0] db_word, bit stray);
    @(negedge clk);
    cfg_write(REG_OFF_S1_X, offs[0]);
    cfg_write(REG_OFF_S1_Y, offs[1]);
    cfg_write(REG_OFF_S2_X, offs[2]);
    cfg_write(REG_OFF_S2_Y, offs[3]);
    cfg_write(REG_DEAD_BAND, db_word);
    // unknown indexes must leave everything untouched
    if (stray)
      for (int k = 1; k <= 3; k++) cfg_write(REG_DEAD_BAND + CFG_IDX_W'(k), 9'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
  endtask

  task automatic check_field(string what, logic signed [31:0] want,
                             logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Stimulus sequence
  initial begin
    logic [3:0][OFF_W-1:0] offs;
    logic [CFG_DATA_W-1:0] db_word;
    tick_input_t           t;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults, then both register extremes
    queue_directed(1'b1);
    drain();
    write_settings({4{9'h100}}, 9'h100, 1'b0);
    queue_directed(1'b0);
    drain();
    write_settings({4{9'h0FF}}, 9'h0FF, 1'b1);
    queue_directed(1'b0);
    drain();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 5))
          0: offs[k] = 9'h100;
          1: offs[k] = 9'h0FF;
          2: offs[k] = '0;
          default: offs[k] = 9'($urandom);
        endcase
      end
      case ($urandom_range(0, 5))
        0: db_word = {1'($urandom_range(0, 1)), 8'h00};
        1: db_word = {1'($urandom_range(0, 1)), 8'hFF};
        default: db_word = 9'($urandom);
      endcase

      // no idling at all in the closing segment
      if (seg == SEGMENTS - 1) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct    = idle_levels[$urandom_range(0, 3)];
        out_stall_pct = idle_levels[$urandom_range(0, 3)];
      end

      write_settings(offs, db_word, $urandom_range(0, 3) == 0);

      repeat (SEG_ITEMS) begin
        for (int k = 0; k < 4; k++) t.raw[k] = rand_axis(k);
        t.pin = 2'($urandom);
        pending_q.push_back(t);
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Input driver: holds a transaction until taken, random gap bursts
  always @(negedge clk) begin
    if (!in_valid || in_done) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0 && in_gap_pct != 0 &&
                   $urandom_range(1, 100) <= in_gap_pct) begin
        gap_left <= $urandom_range(0, 8);
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        in_tick  <= pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (out_stall_pct != 0 && $urandom_range(1, 100) <= out_stall_pct) begin
      stall_left <= $urandom_range(0, 8);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: register shadow, result check, prediction on acceptance
  always @(posedge clk) begin
    tick_result_t want;
    if (!rst_n) begin
      in_done <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OFF_S1_X:  off_reg[0] = cfg_data;
          REG_OFF_S1_Y:  off_reg[1] = cfg_data;
          REG_OFF_S2_X:  off_reg[2] = cfg_data;
          REG_OFF_S2_Y:  off_reg[3] = cfg_data;
          REG_DEAD_BAND: db_reg = cfg_data[DB_W-1:0];
          default: ;
        endcase
        cfg_writes++;
      end

      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result transaction with none expected", $time);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          for (int k = 0; k < 4; k++) begin
            check_field({axis_name[k], "_pos"}, want.pos[k], seen_pos[k]);
            check_field({axis_name[k], "_ctl"}, $signed(want.ctl[k]), $signed(seen_ctl[k]));
          end
          for (int b = 0; b < 2; b++) begin
            check_field({button_name[b], "_held"}, want.held[b], seen_held[b]);
            check_field({button_name[b], "_edge"}, want.edge_code[b], seen_edge[b]);
          end
        end
      end

      if (in_valid && !in_stall) begin
        expected_q.push_back(condition_tick(in_tick, last_pins));
        last_pins = in_tick.pin;
      end
      in_done <= in_valid && !in_stall;
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> sim.f
rtl/jaxc_pkg.sv
rtl/jaxc_div.sv
rtl/joystick_axis_and_button_conditioning_core.sv
tb/sv/testbench.sv
